/* src/dqks_pkg.sv */
// dqks_pkg: shared constants, codes and helpers for the deque with key search
// depth, pointer widths, request and status codes, entry type, ring arithmetic
// no dependencies
package dqks_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = 32;
    localparam int PW    = 32;
    localparam int POS_W = 6;
    localparam int OCC_W = 7;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef logic [AW-1:0] t_slot;
    typedef logic [CW-1:0] t_count;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [PW-1:0] payload;
    } t_entry;

    // ring add, both operands below DEPTH so one compare and subtract is enough
    function automatic t_slot slot_add(input t_slot base, input t_slot off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic t_slot slot_inc(input t_slot s);
        t_slot r;
        if (s == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        t_slot r;
        if (s == '0) begin
            r = AW'(DEPTH - 1);
        end else begin
            r = s - 1'b1;
        end
        return r;
    endfunction

endpackage

/* src/dqks_store.sv */
// dqks_store: entry memory of the deque, one write port and one read port
// read data registered; depends on dqks_pkg
module dqks_store
    import dqks_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_we,
    input  t_slot  i_waddr,
    input  t_entry i_wdata,
    input  t_slot  i_raddr,
    output t_entry o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/deque_with_key_search_unit.sv */
// deque_with_key_search_unit: bounded deque of key and payload entries in a ring buffer
// sequencer, pointers and one key comparator; depends on dqks_pkg and dqks_store
//
// Usage: drive a request word on i_req_type, i_entry_key and i_entry_payload and raise
// start; the word is taken at a rising edge with start high and busy low. Every request
// gives exactly one result word, shown on the o_ result ports for one cycle with o_done
// high. The receiver cannot hold results off and must take each word in that cycle.
// From the accepting edge to the strobe:
//   push, error cases, unused codes: next cycle, busy stays low, one request per cycle
//   pop front or back: busy high for one cycle (one memory read), then the result word
//   search: busy stays high while state S_SRCH scans from position 0 to the match,
//   or to the last occupied entry when there is none. The single key comparator looks
//   at one entry per cycle while the read address walks the ring from the front slot.
// While a pop or search runs, busy holds off new requests; pushes can go back to back.
// Reset (synchronous, active low) empties the queue and zeroes the front pointer;
// the entry memory is not cleared, only occupied slots are ever read.
module deque_with_key_search_unit
    import dqks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_req_type,
    input  logic [KW-1:0]    i_entry_key,
    input  logic [PW-1:0]    i_entry_payload,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [KW-1:0]    o_out_key,
    output logic [PW-1:0]    o_out_payload,
    output logic [POS_W-1:0] o_match_position,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0]       r_state, n_state;
    t_slot            r_front, n_front;
    t_count           r_count, n_count;
    t_slot            r_addr, n_addr;
    t_slot            r_pos, n_pos;
    logic [KW-1:0]    r_key, n_key;
    logic [2:0]       r_req, n_req;
    logic             r_done, n_done;
    logic [1:0]       r_status, n_status;
    logic [KW-1:0]    r_okey, n_okey;
    logic [PW-1:0]    r_opay, n_opay;
    logic [POS_W-1:0] r_opos, n_opos;
    logic [OCC_W-1:0] r_occ, n_occ;

    logic   we;
    t_slot  waddr;
    t_entry wdata;
    t_entry rdata;
    t_count cnt_m1;
    logic   full;
    logic   empty;

    dqks_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_addr),
        .o_rdata (rdata)
    );

    assign cnt_m1 = r_count - 1'b1;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign wdata  = '{key: i_entry_key, payload: i_entry_payload};

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_addr   = r_addr;
        n_pos    = r_pos;
        n_key    = r_key;
        n_req    = r_req;
        n_done   = 1'b0;
        n_status = r_status;
        n_okey   = r_okey;
        n_opay   = r_opay;
        n_opos   = r_opos;
        n_occ    = r_occ;
        we       = 1'b0;
        waddr    = r_front;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key    = i_entry_key;
                    n_req    = i_req_type;
                    n_status = ST_OK;
                    n_okey   = '0;
                    n_opay   = '0;
                    n_opos   = '0;
                    n_occ    = OCC_W'(r_count);
                    case (i_req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                we = 1'b1;
                                if (i_req_type == REQ_PUSH_FRONT) begin
                                    waddr   = slot_dec(r_front);
                                    n_front = slot_dec(r_front);
                                end else begin
                                    waddr = slot_add(r_front, r_count[AW-1:0]);
                                end
                                n_count = r_count + 1'b1;
                                n_occ   = OCC_W'(n_count);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_POP;
                                if (i_req_type == REQ_POP_FRONT) begin
                                    n_addr = r_front;
                                    n_pos  = '0;
                                end else begin
                                    n_addr = slot_add(r_front, cnt_m1[AW-1:0]);
                                    n_pos  = cnt_m1[AW-1:0];
                                end
                            end
                        end
                        REQ_SEARCH: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_state = S_SRCH;
                                n_addr  = r_front;
                                n_pos   = '0;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_okey   = rdata.key;
                n_opay   = rdata.payload;
                n_opos   = POS_W'(r_pos);
                n_count  = cnt_m1;
                n_occ    = OCC_W'(cnt_m1);
                if (r_req == REQ_POP_FRONT) begin
                    n_front = slot_inc(r_front);
                end
                n_state = S_IDLE;
            end
            S_SRCH: begin
                // rdata holds the entry at r_addr, position r_pos from the front
                if (rdata.key == r_key) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_okey   = rdata.key;
                    n_opay   = rdata.payload;
                    n_opos   = POS_W'(r_pos);
                    n_state  = S_IDLE;
                end else if (r_pos == cnt_m1[AW-1:0]) begin
                    n_done   = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_addr = slot_inc(r_addr);
                    n_pos  = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_req    <= n_req;
        r_status <= n_status;
        r_okey   <= n_okey;
        r_opay   <= n_opay;
        r_opos   <= n_opos;
        r_occ    <= n_occ;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_out_key        = r_okey;
    assign o_out_payload    = r_opay;
    assign o_match_position = r_opos;
    assign o_occupancy      = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_count != '0) && (r_pos <= cnt_m1[AW-1:0]))
        else $error("search position beyond occupied entries");

    a_pop_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> o_done && (o_status == ST_OK))
        else $error("pop did not report a word");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with entries held");

endmodule

/* sim/dqks_checker.sv */
// dqks_checker: watches the request and result channels of the deque unit,
// keeps its own copy of the ring and counts every result field that disagrees
// depends on dqks_pkg
module dqks_checker
    import dqks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [2:0]       i_req_type,
    input  logic [KW-1:0]    i_entry_key,
    input  logic [PW-1:0]    i_entry_payload,
    input  logic             i_done,
    input  logic [1:0]       i_status,
    input  logic [KW-1:0]    i_out_key,
    input  logic [PW-1:0]    i_out_payload,
    input  logic [POS_W-1:0] i_match_position,
    input  logic [OCC_W-1:0] i_occupancy,
    output int               o_mismatch_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]       status;
        logic [KW-1:0]    key;
        logic [PW-1:0]    payload;
        logic [POS_W-1:0] position;
        logic [OCC_W-1:0] occupancy;
    } t_dq_result;

    logic [KW-1:0] ring_keys [DEPTH];
    logic [PW-1:0] ring_payloads [DEPTH];
    int            head_slot;
    int            held_count;
    t_dq_result    expected_results [$];
    int            mismatches;

    initial begin
        mismatches       = 0;
        head_slot        = 0;
        held_count       = 0;
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    // applies one request to the ring copy and returns the word the unit should give
    function automatic t_dq_result apply_request(input logic [2:0] req,
                                                 input logic [KW-1:0] key,
                                                 input logic [PW-1:0] payload);
        t_dq_result r;
        int         slot;
        int         pos;
        r.status   = ST_OK;
        r.key      = '0;
        r.payload  = '0;
        r.position = '0;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (held_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (req == REQ_PUSH_FRONT) begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        slot      = head_slot;
                    end else begin
                        slot = (head_slot + held_count) % DEPTH;
                    end
                    ring_keys[slot]     = key;
                    ring_payloads[slot] = payload;
                    held_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos        = (req == REQ_POP_FRONT) ? 0 : held_count - 1;
                    slot       = (head_slot + pos) % DEPTH;
                    r.key      = ring_keys[slot];
                    r.payload  = ring_payloads[slot];
                    r.position = pos[POS_W-1:0];
                    if (req == REQ_POP_FRONT) begin
                        head_slot = (head_slot + 1) % DEPTH;
                    end
                    held_count--;
                end
            end
            REQ_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (pos = 0; pos < held_count; pos++) begin
                    slot = (head_slot + pos) % DEPTH;
                    if (ring_keys[slot] == key) begin
                        r.status   = ST_OK;
                        r.key      = ring_keys[slot];
                        r.payload  = ring_payloads[slot];
                        r.position = pos[POS_W-1:0];
                        break;
                    end
                end
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
        r.occupancy = held_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t ns: %s expected %h got %h", $time, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_dq_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            head_slot  = 0;
            held_count = 0;
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t ns: result word with nothing outstanding", $time);
                    end
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_status));
                    compare_field("key", want.key, i_out_key);
                    compare_field("payload", want.payload, i_out_payload);
                    compare_field("position", 32'(want.position), 32'(i_match_position));
                    compare_field("occupancy", 32'(want.occupancy), 32'(i_occupancy));
                end
            end
            // the word taken at this edge cannot finish before the next one
            if (i_start && !i_busy) begin
                expected_results.push_back(apply_request(i_req_type, i_entry_key,
                                                         i_entry_payload));
            end
        end
        o_pending        <= expected_results.size();
        o_mismatch_count <= mismatches;
    end

endmodule

/* sim/tb_deque_with_key_search_unit.sv */
// tb_deque_with_key_search_unit: drives push, pop and search words into the deque unit
// with random gaps and gives the verdict; depends on dqks_pkg, dqks_checker and the unit
// directed corner words first, then fill, drain, mixed and search-heavy random phases
module tb_deque_with_key_search_unit;
    import dqks_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;
    localparam int         RANDOM_WORDS     = 900;
    localparam int         CALM_TAIL        = 80;
    localparam int         POOL_SIZE        = 12;

    typedef enum int { FILL, DRAIN, MIXED, PROBE } t_phase;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       req_type;
    logic [KW-1:0]    entry_key;
    logic [PW-1:0]    entry_payload;
    logic             done;
    logic [1:0]       res_status;
    logic [KW-1:0]    res_key;
    logic [PW-1:0]    res_payload;
    logic [POS_W-1:0] res_position;
    logic [OCC_W-1:0] res_occupancy;
    int               mismatch_count;
    int               pending;

    logic [KW-1:0]    key_pool [POOL_SIZE];

    deque_with_key_search_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (req_type),
        .i_entry_key      (entry_key),
        .i_entry_payload  (entry_payload),
        .o_done           (done),
        .o_status         (res_status),
        .o_out_key        (res_key),
        .o_out_payload    (res_payload),
        .o_match_position (res_position),
        .o_occupancy      (res_occupancy)
    );

    dqks_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_req_type       (req_type),
        .i_entry_key      (entry_key),
        .i_entry_payload  (entry_payload),
        .i_done           (done),
        .i_status         (res_status),
        .i_out_key        (res_key),
        .i_out_payload    (res_payload),
        .i_match_position (res_position),
        .i_occupancy      (res_occupancy),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // holds the word until an edge with busy low takes it
    task automatic send_word(input logic [2:0] req, input logic [KW-1:0] key,
                             input logic [PW-1:0] payload);
        @(negedge i_clk);
        start         <= 1'b1;
        req_type      <= req;
        entry_key     <= key;
        entry_payload <= payload;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic rest(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic settle();
        rest(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [KW-1:0] pick_key();
        if ($urandom_range(0, 3) != 0) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_request(input t_phase ph);
        int roll;
        int push_pct;
        int pop_pct;
        case (ph)
            FILL:    begin push_pct = 85; pop_pct = 5;  end
            DRAIN:   begin push_pct = 5;  pop_pct = 85; end
            MIXED:   begin push_pct = 40; pop_pct = 35; end
            default: begin push_pct = 20; pop_pct = 20; end
        endcase
        if ($urandom_range(0, 99) < 3) begin
            return 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
        end
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        end
        if (roll < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        end
        return REQ_SEARCH;
    endfunction

    initial begin
        logic [2:0] req;
        t_phase     ph;
        int         words_sent;
        int         phase_no;
        int         phase_len;
        bit         idle_on;
        start         = 1'b0;
        i_rst_n       = 1'b0;
        req_type      = REQ_PUSH_FRONT;
        entry_key     = '0;
        entry_payload = '0;
        foreach (key_pool[j]) key_pool[j] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corners and the ignored codes
        send_word(REQ_POP_FRONT, key_pool[2], $urandom());
        send_word(REQ_POP_BACK, key_pool[3], $urandom());
        send_word(REQ_SEARCH, '0, '0);
        for (int c = REQ_FIRST_UNUSED; c <= REQ_LAST_UNUSED; c++) begin
            send_word(3'(c), $urandom(), $urandom());
        end
        // popping the only word from either end empties the queue
        send_word(REQ_PUSH_FRONT, '0, '0);
        send_word(REQ_POP_FRONT, '1, '1);
        rest(2);
        send_word(REQ_PUSH_BACK, '1, '1);
        send_word(REQ_POP_BACK, '0, '0);
        send_word(REQ_PUSH_BACK, key_pool[2], $urandom());
        send_word(REQ_PUSH_FRONT, key_pool[3], $urandom());
        send_word(REQ_PUSH_BACK, key_pool[4], '1);
        send_word(REQ_PUSH_BACK, key_pool[3], $urandom());
        send_word(REQ_SEARCH, key_pool[4], '0);
        send_word(REQ_SEARCH, key_pool[3], '0);
        send_word(REQ_SEARCH, key_pool[5], '0);
        send_word(REQ_POP_BACK, '0, '0);
        send_word(REQ_SEARCH, key_pool[2], '0);
        rest(3);
        send_word(REQ_POP_FRONT, '0, '0);
        send_word(REQ_POP_FRONT, '0, '0);
        send_word(REQ_POP_BACK, '0, '0);
        send_word(REQ_POP_BACK, '0, '0);
        settle();

        words_sent = 0;
        phase_no   = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (phase_no == 0) begin
                ph = FILL;
            end else if (phase_no == 1) begin
                ph = DRAIN;
            end else begin
                ph = t_phase'($urandom_range(0, 3));
            end
            // fill and drain run long enough to hit full and empty from any level
            phase_len = (ph == FILL || ph == DRAIN) ? $urandom_range(100, 160)
                                                    : $urandom_range(40, 120);
            idle_on   = $urandom_range(0, 2) != 0;
            for (int k = 0; k < phase_len && words_sent < RANDOM_WORDS; k++) begin
                req = pick_request(ph);
                send_word(req, pick_key(), $urandom());
                if (req <= REQ_SEARCH) begin
                    words_sent++;
                end
                if (idle_on && words_sent < RANDOM_WORDS - CALM_TAIL &&
                    $urandom_range(0, 3) == 0) begin
                    rest($urandom_range(1, 4));
                end
            end
            if (phase_no == 0 || (words_sent < RANDOM_WORDS - CALM_TAIL &&
                                  $urandom_range(0, 2) == 0)) begin
                settle();
            end
            phase_no++;
        end

        settle();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
